/* rtl/urb64_pkg.sv */
// Shared types, constants and character functions of the serial relay framer.
`timescale 1ns / 1ps
`default_nettype none

package urb64_pkg;

  localparam int REM_W = 6;
  localparam int STOP_CAP_BYTES = 45;
  localparam int GROUP_BYTES = 3;
  localparam logic [7:0] PORT_DIGIT_RESET = 8'd49;
  localparam logic [7:0] PAD_CHAR = "=";
  localparam logic [3:0] HDR_LAST = 4'd11;
  localparam logic [3:0] B64_LAST = 4'd3;
  localparam logic [3:0] TRL_LAST = 4'd2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_POLL  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam logic [1:0] CFG_ID_FIRST  = 2'd0;
  localparam logic [1:0] CFG_ID_SECOND = 2'd1;
  localparam logic [1:0] CFG_PORT      = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       overrun_seen;
  } out_t;

  typedef enum logic [1:0] {
    SRC_HDR = 2'd0,
    SRC_B64 = 2'd1,
    SRC_TRL = 2'd2
  } src_t;

  typedef struct packed {
    logic start;
    logic wr;
    logic poll;
    logic stop;
    logic grp_init;
    logic rd;
    logic cap;
    logic emit;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic poll_go;
    logic stop_go;
    logic byte_last;
    logic emit_last;
    logic more;
    logic poll_mode;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = "+";
    end else begin
      r = "/";
    end
    return r;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [3:0] idx, input logic [7:0] id_first,
                                          input logic [7:0] id_second,
                                          input logic [7:0] port_digit);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "$";
      4'd1:    r = id_first;
      4'd2:    r = id_second;
      4'd3:    r = "E";
      4'd4:    r = "0";
      4'd5:    r = "5";
      4'd6:    r = ",";
      4'd7:    r = "7";
      4'd8:    r = "7";
      4'd9:    r = ",";
      4'd10:   r = port_digit;
      default: r = ",";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trl_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = ",";
      2'd1:    r = 8'h0A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/uart_ring_base64_relay_core.sv */
// Top level of the serial relay framer: ring buffer with base64 output framing.
`timescale 1ns / 1ps
`default_nettype none

// Requests are taken one at a time. A received-byte request produces no output. A start
// request emits its 12 header characters at one per cycle while the output side takes
// them. A poll or stop works through each group of up to three bytes in turn (one setup
// step, a registered memory read plus capture for each byte, then four characters); a
// stop adds three trailer characters. The ring holds RING_DEPTH-1 bytes and needs no
// clearing after reset. Configuration writes are taken on every cycle.
module uart_ring_base64_relay_core #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_CHUNK_BYTES = 48
) (
  input  wire             logic clk,
  input  wire             logic rst,
  input  wire             logic in_valid,
  output logic            in_ready,
  input  urb64_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             logic out_ready,
  output urb64_pkg::out_t out_data,
  input  wire             logic cfg_valid,
  output logic            cfg_ready,
  input  wire             logic [1:0] cfg_index,
  input  wire             logic [7:0] cfg_data
);

  urb64_pkg::cmd_t  cmd;
  urb64_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  urb64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (in_data.command),
    .stat     (stat),
    .cmd      (cmd)
  );

  urb64_dp #(
    .RING_DEPTH      (RING_DEPTH),
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .rx_byte   (in_data.rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.wr, cmd.poll, cmd.stop, cmd.grp_init, cmd.rd, cmd.cap, cmd.emit}))
    else $error("more than one datapath command at once");

  a_rd_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> cmd.cap)
    else $error("ring read data not captured");

  a_hdr_clean: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.src == urb64_pkg::SRC_HDR) |=> !out_data.overrun_seen)
    else $error("header character carries overrun");

endmodule

`default_nettype wire

/* rtl/urb64_dp.sv */
// Datapath: ring memory, pointers, group assembly, character generation, output register.
`timescale 1ns / 1ps
`default_nettype none

module urb64_dp #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_CHUNK_BYTES = 48
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  urb64_pkg::cmd_t    cmd,
  output urb64_pkg::stat_t   stat,
  input  wire                logic [7:0] rx_byte,
  input  wire                logic cfg_valid,
  input  wire                logic [1:0] cfg_index,
  input  wire                logic [7:0] cfg_data,
  output logic               out_valid,
  input  wire                logic out_ready,
  output urb64_pkg::out_t    out_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CW = (PTR_W > urb64_pkg::REM_W) ? PTR_W : urb64_pkg::REM_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [urb64_pkg::REM_W-1:0] GRP = urb64_pkg::REM_W'(urb64_pkg::GROUP_BYTES);

  logic [7:0] mem [RING_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic overrun;
  logic listening;
  logic [7:0] id_first;
  logic [7:0] id_second;
  logic [7:0] port_digit;
  logic [urb64_pkg::REM_W-1:0] rem;
  logic [1:0] take;
  logic [1:0] k;
  logic [7:0] grp [3];
  logic [7:0] rdata;
  logic [3:0] cidx;
  logic poll_mode;

  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic full;
  logic [PTR_W-1:0] cnt;
  logic [CW-1:0] cnt_x;
  logic [urb64_pkg::REM_W-1:0] poll_len;
  logic [urb64_pkg::REM_W-1:0] stop_len;
  logic [1:0] take_new;
  logic more;
  logic out_free;
  logic [23:0] w;
  logic [5:0] sextet;
  logic pad;
  logic [7:0] ch;
  logic last;
  logic run;
  logic byte_ok;

  always_comb begin
    wp_inc = (wp == PTR_LAST) ? '0 : wp + 1'b1;
    rp_inc = (rp == PTR_LAST) ? '0 : rp + 1'b1;
    full = (wp_inc == rp);
    byte_ok = listening && !overrun;
    if (wp >= rp) begin
      cnt = wp - rp;
    end else begin
      cnt = PTR_W'(({1'b0, wp} + DEPTH_X) - {1'b0, rp});
    end
    cnt_x = CW'(cnt);
    poll_len = (cnt_x > CW'(MAX_CHUNK_BYTES)) ? urb64_pkg::REM_W'(MAX_CHUNK_BYTES)
                                               : urb64_pkg::REM_W'(cnt_x);
    stop_len = (cnt_x > CW'(urb64_pkg::STOP_CAP_BYTES))
               ? urb64_pkg::REM_W'(urb64_pkg::STOP_CAP_BYTES) : urb64_pkg::REM_W'(cnt_x);
    take_new = (rem >= GRP) ? 2'd3 : rem[1:0];
    more = poll_mode ? (rem >= GRP) : (rem != '0);
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    w = {grp[0], grp[1], grp[2]};
    case (cidx[1:0])
      2'd0:    sextet = w[23:18];
      2'd1:    sextet = w[17:12];
      2'd2:    sextet = w[11:6];
      default: sextet = w[5:0];
    endcase
    pad = ((cidx[1:0] == 2'd2) && (take < 2'd2)) || ((cidx[1:0] == 2'd3) && (take < 2'd3));
    case (cmd.src)
      urb64_pkg::SRC_HDR: begin
        ch = urb64_pkg::hdr_char(cidx, id_first, id_second, port_digit);
        last = (cidx == urb64_pkg::HDR_LAST);
        run = last;
      end
      urb64_pkg::SRC_B64: begin
        ch = pad ? urb64_pkg::PAD_CHAR : urb64_pkg::b64_char(sextet);
        last = (cidx == urb64_pkg::B64_LAST);
        run = last && poll_mode && !more;
      end
      urb64_pkg::SRC_TRL: begin
        ch = urb64_pkg::trl_char(cidx[1:0]);
        last = (cidx == urb64_pkg::TRL_LAST);
        run = last;
      end
      default: begin
        ch = '0;
        last = 1'b1;
        run = 1'b1;
      end
    endcase
  end

  always_comb begin
    stat.poll_go = !overrun && (poll_len >= GRP);
    stat.stop_go = !overrun && (stop_len != '0);
    stat.byte_last = (k == take - 2'd1);
    stat.emit_last = last;
    stat.more = more;
    stat.poll_mode = poll_mode;
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      overrun <= 1'b0;
      listening <= 1'b0;
      id_first <= '0;
      id_second <= '0;
      port_digit <= urb64_pkg::PORT_DIGIT_RESET;
      rem <= '0;
      take <= '0;
      k <= '0;
      cidx <= '0;
      poll_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          urb64_pkg::CFG_ID_FIRST:  id_first <= cfg_data;
          urb64_pkg::CFG_ID_SECOND: id_second <= cfg_data;
          urb64_pkg::CFG_PORT:      port_digit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        wp <= '0;
        rp <= '0;
        overrun <= 1'b0;
        listening <= 1'b1;
      end
      if (cmd.wr && byte_ok) begin
        if (full) begin
          overrun <= 1'b1;
        end else begin
          wp <= wp_inc;
        end
      end
      if (cmd.poll) begin
        rem <= poll_len;
        poll_mode <= 1'b1;
      end
      if (cmd.stop) begin
        listening <= 1'b0;
        rem <= overrun ? '0 : stop_len;
        poll_mode <= 1'b0;
      end
      if (cmd.grp_init) begin
        take <= take_new;
        rem <= rem - urb64_pkg::REM_W'(take_new);
        k <= '0;
      end
      if (cmd.rd) begin
        rp <= rp_inc;
      end
      if (cmd.cap) begin
        k <= k + 2'd1;
      end
      if (cmd.emit) begin
        cidx <= last ? '0 : cidx + 4'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && byte_ok && !full) begin
      mem[wp] <= rx_byte;
    end
    if (cmd.rd) begin
      rdata <= mem[rp];
    end
    if (cmd.grp_init) begin
      grp[0] <= '0;
      grp[1] <= '0;
      grp[2] <= '0;
    end else if (cmd.cap) begin
      grp[k] <= rdata;
    end
    if (cmd.emit) begin
      out_data.out_char <= ch;
      out_data.run_last <= run;
      out_data.overrun_seen <= overrun;
    end
  end

endmodule

`default_nettype wire

/* rtl/urb64_ctrl.sv */
// Controller: sequences header, group read, base64 emission and trailer.
`timescale 1ns / 1ps
`default_nettype none

module urb64_ctrl (
  input  wire              logic clk,
  input  wire              logic rst,
  input  wire              logic in_valid,
  output logic             in_ready,
  input  wire              logic [1:0] command,
  input  urb64_pkg::stat_t stat,
  output urb64_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HDR  = 7'b0000010,
    S_GRP  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CAP  = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_TRL  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.src = urb64_pkg::SRC_HDR;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            urb64_pkg::CMD_START: begin
              cmd.start = 1'b1;
              state_next = S_HDR;
            end
            urb64_pkg::CMD_BYTE: cmd.wr = 1'b1;
            urb64_pkg::CMD_POLL: begin
              cmd.poll = 1'b1;
              if (stat.poll_go) begin
                state_next = S_GRP;
              end
            end
            default: begin
              cmd.stop = 1'b1;
              state_next = stat.stop_go ? S_GRP : S_TRL;
            end
          endcase
        end
      end
      S_HDR: begin
        cmd.src = urb64_pkg::SRC_HDR;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_GRP: begin
        cmd.grp_init = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        state_next = stat.byte_last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        cmd.src = urb64_pkg::SRC_B64;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            if (stat.more) begin
              state_next = S_GRP;
            end else if (stat.poll_mode) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_TRL;
            end
          end
        end
      end
      S_TRL: begin
        cmd.src = urb64_pkg::SRC_TRL;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
